// ----- hdl/bde_pkg.sv -----
// ----------------------------------------------------------------------------
// bde_pkg: shared types and constants for the button debounce event detector
// Holds the transfer payload structs, the register map and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package bde_pkg;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned StampW   = 32;
  localparam int unsigned CountW   = 16;

  // Register indexes of the configuration port.
  localparam logic [CfgIdxW-1:0] REG_PRESSED_LEVEL     = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_DEBOUNCE_ENABLE   = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_DEBOUNCE_MS       = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_HOLD_THRESHOLD_MS = 2'd3;

  // Register reset values.
  localparam logic                RST_PRESSED_LEVEL     = 1'b0;
  localparam logic                RST_DEBOUNCE_ENABLE   = 1'b1;
  localparam logic [CfgDataW-1:0] RST_DEBOUNCE_MS       = 16'd50;
  localparam logic [CfgDataW-1:0] RST_HOLD_THRESHOLD_MS = 16'd1000;

  typedef struct packed {
    logic              pin_level;
    logic [StampW-1:0] now_ms;
  } in_t;

  typedef struct packed {
    logic              pressed;
    logic              changed;
    logic              press_event;
    logic              release_event;
    logic              click_event;
    logic              hold_event;
    logic [CountW-1:0] press_count;
    logic [StampW-1:0] hold_time_ms;
  } out_t;

  typedef struct packed {
    logic                pressed_level;
    logic                debounce_enable;
    logic [CfgDataW-1:0] debounce_ms;
    logic [CfgDataW-1:0] hold_threshold_ms;
  } cfg_t;

endpackage

`default_nettype wire

// ----- hdl/bde_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// bde_cfg_regs: configuration register file
// Write-only registers loaded from the plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module bde_cfg_regs (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [bde_pkg::CfgIdxW-1:0]    cfg_index,
  input  wire logic [bde_pkg::CfgDataW-1:0]   cfg_data,
  output bde_pkg::cfg_t                       cfg
);

  bde_pkg::cfg_t cfg_r;
  bde_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        bde_pkg::REG_PRESSED_LEVEL:     cfg_nxt.pressed_level     = cfg_data[0];
        bde_pkg::REG_DEBOUNCE_ENABLE:   cfg_nxt.debounce_enable   = cfg_data[0];
        bde_pkg::REG_DEBOUNCE_MS:       cfg_nxt.debounce_ms       = cfg_data;
        bde_pkg::REG_HOLD_THRESHOLD_MS: cfg_nxt.hold_threshold_ms = cfg_data;
        default:                        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pressed_level     <= bde_pkg::RST_PRESSED_LEVEL;
      cfg_r.debounce_enable   <= bde_pkg::RST_DEBOUNCE_ENABLE;
      cfg_r.debounce_ms       <= bde_pkg::RST_DEBOUNCE_MS;
      cfg_r.hold_threshold_ms <= bde_pkg::RST_HOLD_THRESHOLD_MS;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// ----- hdl/bde_core.sv -----
// ----------------------------------------------------------------------------
// bde_core: debounce and event logic
// Holds the button state and computes one result per sample in one pass.
// ----------------------------------------------------------------------------
`default_nettype none

module bde_core (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          step,
  input  wire bde_pkg::in_t  item,
  input  wire bde_pkg::cfg_t cfg,
  output bde_pkg::out_t      result
);

  logic                           pressed_r, pressed_nxt;
  logic [bde_pkg::StampW-1:0]     last_change_r, last_change_nxt;
  logic [bde_pkg::StampW-1:0]     press_start_r, press_start_nxt;
  logic                           timing_r, timing_nxt;
  logic                           fired_r, fired_nxt;
  logic [bde_pkg::CountW-1:0]     count_r, count_nxt;

  logic                           level_diff;
  logic                           too_soon;
  logic                           take_change;
  logic                           ev_press;
  logic                           ev_release;
  logic                           ev_hold;
  logic [bde_pkg::StampW-1:0]     change_elapsed;
  logic [bde_pkg::StampW-1:0]     press_elapsed;

  always_comb begin
    pressed_nxt    = (item.pin_level == cfg.pressed_level);
    level_diff     = (pressed_nxt != pressed_r);
    change_elapsed = item.now_ms - last_change_r;
    press_elapsed  = item.now_ms - press_start_r;
    too_soon       = cfg.debounce_enable &&
                     (change_elapsed < {{(bde_pkg::StampW-bde_pkg::CfgDataW){1'b0}},
                                        cfg.debounce_ms});
    take_change    = level_diff && !too_soon;
    ev_press       = take_change && pressed_nxt;
    ev_release     = take_change && !pressed_nxt;
    // Hold is only checked on a steady sample, and fires once per press.
    ev_hold        = !level_diff && timing_r && !fired_r &&
                     (press_elapsed > {{(bde_pkg::StampW-bde_pkg::CfgDataW){1'b0}},
                                       cfg.hold_threshold_ms});

    last_change_nxt = take_change ? item.now_ms : last_change_r;
    press_start_nxt = ev_press ? item.now_ms : press_start_r;
    count_nxt       = ev_press ? count_r + 1'b1 : count_r;
    timing_nxt      = ev_press ? 1'b1 : (ev_release ? 1'b0 : timing_r);
    fired_nxt       = ev_press ? 1'b0 : (ev_hold ? 1'b1 : fired_r);

    result.pressed       = pressed_nxt;
    result.changed       = take_change;
    result.press_event   = ev_press;
    result.release_event = ev_release;
    result.click_event   = ev_release;
    result.hold_event    = ev_hold;
    result.press_count   = count_nxt;
    // A fresh press starts timing at this very sample, so its hold time is zero.
    result.hold_time_ms  = (timing_nxt && !ev_press) ? press_elapsed : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pressed_r     <= 1'b0;
      last_change_r <= '0;
      press_start_r <= '0;
      timing_r      <= 1'b0;
      fired_r       <= 1'b1;
      count_r       <= '0;
    end else if (step) begin
      pressed_r     <= pressed_nxt;
      last_change_r <= last_change_nxt;
      press_start_r <= press_start_nxt;
      timing_r      <= timing_nxt;
      fired_r       <= fired_nxt;
      count_r       <= count_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/button_debounce_event_detector.sv -----
// ----------------------------------------------------------------------------
// button_debounce_event_detector: push-button debouncer with hold detection
// Turns time-stamped pin samples into press, release, click and hold events.
// ----------------------------------------------------------------------------
//
//   Port group   Direction   Handshake          Payload
//   in_*         input       in_valid/in_stall   bde_pkg::in_t
//   out_*        output      out_valid/out_stall bde_pkg::out_t
//   cfg_*        input       cfg_we              index and 16-bit data
//
// A sample is registered on transfer, evaluated once it can advance and
// its result registered in the result register for output transfer.
// One sample is taken every cycle while the output side keeps draining.
// The input register and the result register each hold one item, so the
// input side stalls only when both are full and out_stall is high.
// Reset is synchronous: it clears the button state and loads register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module button_debounce_event_detector (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output      logic                         in_stall,
  input  wire bde_pkg::in_t                 in_data,
  output      logic                         out_valid,
  input  wire logic                         out_stall,
  output bde_pkg::out_t                     out_data,
  input  wire logic                         cfg_we,
  input  wire logic [bde_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [bde_pkg::CfgDataW-1:0] cfg_data
);

  bde_pkg::cfg_t  cfg;
  bde_pkg::in_t   s1_data_r;
  bde_pkg::out_t  out_data_r;
  bde_pkg::out_t  result;
  logic           s1_valid_r, s1_valid_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic           advance;
  logic           in_xfer;

  bde_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bde_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (advance),
    .item   (s1_data_r),
    .cfg    (cfg),
    .result (result)
  );

  always_comb begin
    advance       = s1_valid_r && (!out_valid_r || !out_stall);
    in_stall      = s1_valid_r && !advance;
    in_xfer       = in_valid && !in_stall;
    s1_valid_nxt  = in_xfer || (s1_valid_r && !advance);
    out_valid_nxt = advance || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_data_r <= in_data;
    end
    if (advance) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire
